/* rtl/spe_pkg.sv */
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants of the segment pooling engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spe_pkg;

  localparam int COLUMNS_DEF      = 256;
  localparam int MAX_ROWS_DEF     = 65536;
  localparam int MAX_SEG_ROWS_DEF = 1024;

  localparam int SAMPLE_W   = 16;
  localparam int COL_W      = 8;
  localparam int ACC_W      = 26;
  localparam int SRC_W      = 17;
  localparam int MODE_W     = 2;
  localparam int NCOL_W     = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int Q_DEPTH    = 2;

  localparam logic [NCOL_W-1:0] NCOL_RESET = NCOL_W'(256);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOLING_MODE   = 1'b0,
    REG_COLUMNS_IN_USE = 1'b1
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_MAX  = 2'd0,
    MODE_SUM  = 2'd1,
    MODE_MEAN = 2'd2,
    MODE_SUM3 = 2'd3
  } pool_mode_t;

  typedef enum logic {
    ACT_DATA  = 1'b0,
    ACT_EMPTY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_DIV,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    action_t                    act;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COL_W-1:0]           col;
    logic                       last;
    logic                       seg_end;
    logic                       begins;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/spe_ifs.sv */
// ----------------------------------------------------------------------------
// spe_ifs
// Valid/ready channels: element input, pooled result output, config writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spe_in_if import spe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] sample;
  logic [COL_W-1:0]           column;
  logic                       segment_end;
  logic                       input_begins;

  modport source (output valid, action, sample, column, segment_end, input_begins,
                  input ready);
  modport sink   (input valid, action, sample, column, segment_end, input_begins,
                  output ready);
endinterface

interface spe_out_if import spe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] pooled_value;
  logic signed [SRC_W-1:0] source_row;
  logic [COL_W-1:0]        out_column;
  logic                    last_of_segment;

  modport source (output valid, pooled_value, source_row, out_column, last_of_segment,
                  input ready);
  modport sink   (input valid, pooled_value, source_row, out_column, last_of_segment,
                  output ready);
endinterface

interface spe_cfg_if import spe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

/* rtl/segment_pooling_engine.sv */
// ----------------------------------------------------------------------------
// segment_pooling_engine
// Flow: one command at a time; idle pops the queue head and reads its column
//   entry. An element that does not end a segment is written back; a segment
//   end clears the column and loads the max or sum result, or for mean first
//   runs the bit-serial divider. Empty segment markers go straight to emit,
//   which registers the result beat once the output register is free.
// Reset: rst_n clears counters, config and per-column valid bits at once;
//   no clearing pass, the column memory is masked by the valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_pooling_engine import spe_pkg::*; #(
  parameter int COLUMNS          = COLUMNS_DEF,
  parameter int MAX_ROWS         = MAX_ROWS_DEF,
  parameter int MAX_SEGMENT_ROWS = MAX_SEG_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spe_in_if.sink    in_ch,
  spe_out_if.source out_ch,
  spe_cfg_if.sink   cfg_ch
);

  logic       q_full;
  logic       push;
  cmd_t       push_cmd;
  logic       q_pop;
  logic       q_valid;
  cmd_t       q_head;
  pool_mode_t mode;

  spe_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .mode     (mode)
  );

  spe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  spe_back #(
    .COLUMNS          (COLUMNS),
    .MAX_ROWS         (MAX_ROWS),
    .MAX_SEGMENT_ROWS (MAX_SEGMENT_ROWS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/spe_front.sv */
// ----------------------------------------------------------------------------
// spe_front
// Config registers and element classification: drops unused columns, flags
// the last column in use and queues data and empty-segment beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spe_front import spe_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  spe_in_if.sink     in_ch,
  spe_cfg_if.sink    cfg_ch,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd,
  output pool_mode_t mode
);

  localparam int NC_W = ($clog2(COLUMNS + 1) > NCOL_W) ? $clog2(COLUMNS + 1) : NCOL_W;

  pool_mode_t        mode_r;
  logic [NCOL_W-1:0] cols_r;
  logic [NC_W-1:0]   cols_ext;
  logic [NC_W-1:0]   ncols;
  logic [NC_W-1:0]   col_ext;
  logic              in_range;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign mode         = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MAX;
      cols_r <= NCOL_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.idx))
        REG_POOLING_MODE:   mode_r <= pool_mode_t'(cfg_ch.data[MODE_W-1:0]);
        REG_COLUMNS_IN_USE: cols_r <= cfg_ch.data[NCOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_ext = NC_W'(cols_r);
    if (cols_ext == '0) begin
      ncols = NC_W'(1);
    end else if (cols_ext > NC_W'(COLUMNS)) begin
      ncols = NC_W'(COLUMNS);
    end else begin
      ncols = cols_ext;
    end
    col_ext  = NC_W'(in_ch.column);
    in_range = col_ext < ncols;
  end

  always_comb begin
    push             = in_ch.valid && in_ch.ready && in_range;
    push_cmd.act     = action_t'(in_ch.action);
    push_cmd.sample  = in_ch.sample;
    push_cmd.col     = in_ch.column;
    push_cmd.last    = col_ext == (ncols - NC_W'(1));
    push_cmd.seg_end = in_ch.segment_end;
    push_cmd.begins  = in_ch.input_begins;
  end

endmodule

`default_nettype wire

/* rtl/spe_queue.sv */
// ----------------------------------------------------------------------------
// spe_queue
// Short command queue between the classifier and the accumulator engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spe_queue import spe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  cmd_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full       = count_r == (PTR_W + 1)'(Q_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W + 1)'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

/* rtl/spe_back.sv */
// ----------------------------------------------------------------------------
// spe_back
// Per-column read-modify-write of max/sum accumulators, row counters,
// bit-serial mean divider and the registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spe_back import spe_pkg::*; #(
  parameter int COLUMNS          = COLUMNS_DEF,
  parameter int MAX_ROWS         = MAX_ROWS_DEF,
  parameter int MAX_SEGMENT_ROWS = MAX_SEG_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pool_mode_t mode,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  spe_out_if.source  out_ch
);

  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int SEG_W = $clog2(MAX_SEGMENT_ROWS + 1);
  localparam int CNT_W = $clog2(ACC_W);

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic                    has_row;
    logic [ROW_W-1:0]        row;
  } entry_t;

  back_state_t state_r, state_nxt;

  entry_t                  col_mem [COLUMNS];
  entry_t                  rd_entry_r;
  logic [COLUMNS-1:0]      valid_r;
  cmd_t                    cmd_r;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [SEG_W-1:0]        seg_r, seg_nxt;
  logic signed [ACC_W-1:0] res_val_r;
  logic signed [SRC_W-1:0] res_src_r;
  logic [ACC_W-1:0]        quo_r;
  logic [SEG_W-1:0]        rem_r;
  logic [SEG_W-1:0]        divisor_r;
  logic                    neg_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    out_valid_r;
  logic signed [ACC_W-1:0] out_val_r;
  logic signed [SRC_W-1:0] out_src_r;
  logic [COL_W-1:0]        out_col_r;
  logic                    out_last_r;

  logic                    out_free;
  logic                    clr_all, mem_we, clr_one, div_start;
  logic                    res_ld_read, res_ld_div, res_ld_mark, out_ld;
  logic [IDX_W-1:0]        idx_rd, idx_c;
  logic signed [ACC_W-1:0] cur_acc, samp_ext, acc_mag;
  logic                    cur_has;
  logic [ROW_W-1:0]        row_use;
  logic [SEG_W-1:0]        seg_use;
  logic signed [ACC_W:0]   sum_w;
  logic signed [ACC_W-1:0] sum_sat;
  entry_t                  new_entry;
  logic signed [SRC_W-1:0] src_val;
  logic [SEG_W:0]          trial;
  logic                    ge;
  logic [SEG_W-1:0]        rem_step;
  logic [ACC_W-1:0]        quo_step;
  logic signed [ACC_W-1:0] quo_signed;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_head.act == ACT_EMPTY) ? B_EMIT : B_READ;
        end
      end
      B_READ: begin
        if (cmd_r.seg_end) begin
          state_nxt = (mode == MODE_MEAN) ? B_DIV : B_EMIT;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = (state_r == B_IDLE) && q_valid;
    clr_all     = q_pop && (q_head.act == ACT_DATA) && q_head.begins;
    res_ld_mark = q_pop && (q_head.act == ACT_EMPTY);
    mem_we      = (state_r == B_READ) && !cmd_r.seg_end;
    clr_one     = (state_r == B_READ) && cmd_r.seg_end;
    div_start   = clr_one && (mode == MODE_MEAN);
    res_ld_read = clr_one && (mode != MODE_MEAN);
    res_ld_div  = (state_r == B_DIV) && (cnt_r == '0);
    out_ld      = (state_r == B_EMIT) && out_free;
  end

  // accumulate
  always_comb begin
    idx_rd   = IDX_W'(q_head.col);
    idx_c    = IDX_W'(cmd_r.col);
    cur_acc  = valid_r[idx_c] ? rd_entry_r.acc : '0;
    cur_has  = valid_r[idx_c] && rd_entry_r.has_row;
    samp_ext = ACC_W'(cmd_r.sample);
    row_use  = cmd_r.begins ? '0 : row_r;
    seg_use  = cmd_r.begins ? '0 : seg_r;
    sum_w    = (ACC_W + 1)'(cur_acc) + (ACC_W + 1)'(samp_ext);
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sum_sat = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_w[ACC_W-1:0];
    end
    new_entry.acc     = cur_acc;
    new_entry.has_row = cur_has;
    new_entry.row     = rd_entry_r.row;
    if (mode == MODE_MAX) begin
      if (samp_ext > cur_acc) begin
        new_entry.acc     = samp_ext;
        new_entry.has_row = 1'b1;
        new_entry.row     = row_use;
      end
    end else begin
      new_entry.acc = sum_sat;
    end
    src_val = ((mode == MODE_MAX) && new_entry.has_row) ? SRC_W'(new_entry.row) : '1;
    acc_mag = new_entry.acc[ACC_W-1] ? -new_entry.acc : new_entry.acc;

    row_nxt = row_use;
    seg_nxt = seg_use;
    if (cmd_r.last) begin
      if (row_use < ROW_W'(MAX_ROWS - 1)) begin
        row_nxt = row_use + ROW_W'(1);
      end
      if (cmd_r.seg_end) begin
        seg_nxt = '0;
      end else if (seg_use < SEG_W'(MAX_SEGMENT_ROWS - 1)) begin
        seg_nxt = seg_use + SEG_W'(1);
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    trial      = {rem_r, quo_r[ACC_W-1]};
    ge         = trial >= {1'b0, divisor_r};
    rem_step   = ge ? SEG_W'(trial - {1'b0, divisor_r}) : trial[SEG_W-1:0];
    quo_step   = {quo_r[ACC_W-2:0], ge};
    quo_signed = neg_r ? -$signed(quo_step) : $signed(quo_step);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_entry_r <= col_mem[idx_rd];
      cmd_r      <= q_head;
    end
    if (mem_we) begin
      col_mem[idx_c] <= new_entry;
    end
    if (res_ld_mark) begin
      res_val_r <= '0;
      res_src_r <= '1;
    end else if (res_ld_read) begin
      res_val_r <= new_entry.acc;
      res_src_r <= src_val;
    end else if (res_ld_div) begin
      res_val_r <= quo_signed;
      res_src_r <= '1;
    end
    if (div_start) begin
      quo_r     <= acc_mag;
      rem_r     <= '0;
      divisor_r <= seg_use + SEG_W'(1);
      neg_r     <= new_entry.acc[ACC_W-1];
      cnt_r     <= CNT_W'(ACC_W - 1);
    end else if (state_r == B_DIV) begin
      quo_r <= quo_step;
      rem_r <= rem_step;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (out_ld) begin
      out_val_r  <= res_val_r;
      out_src_r  <= res_src_r;
      out_col_r  <= cmd_r.col;
      out_last_r <= cmd_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      row_r       <= '0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_all) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[idx_c] <= 1'b1;
      end else if (clr_one) begin
        valid_r[idx_c] <= 1'b0;
      end
      if (state_r == B_READ) begin
        row_r <= row_nxt;
        seg_r <= seg_nxt;
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pooled_value    = out_val_r;
  assign out_ch.source_row      = out_src_r;
  assign out_ch.out_column      = out_col_r;
  assign out_ch.last_of_segment = out_last_r;

`ifndef NO_ASSERTIONS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DIV |-> divisor_r != '0) else $error("mean divisor is zero");
  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == B_EMIT)
    else $error("result beat raised outside emit");
`endif

endmodule

`default_nettype wire

/* dv/segment_pooling_engine_tb.sv */
// ----------------------------------------------------------------------------
// segment_pooling_engine_tb
// Self-checking bench for the segment pooling engine. Feature matrices are
// streamed in row-major order through the element channel while an in-bench
// model folds each beat into its own per-column max/sum state. Every pooled
// result beat is checked field by field against the oldest prediction.
// Directed cases cover the modes, column limits, empty markers and mode
// changes mid-segment; random matrices run under three idling profiles; a
// long single-column segment drives the sum into its clamp and the segment
// row count to its ceiling, followed by a long result stall that backs up
// the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_pooling_engine_tb import spe_pkg::*; ();

  localparam int  COLUMNS       = COLUMNS_DEF;
  localparam int  MAX_ROWS      = MAX_ROWS_DEF;
  localparam int  MAX_SEG_ROWS  = MAX_SEG_ROWS_DEF;
  localparam int  SETTLE_CYCLES = 40;
  localparam int  SAT_ROWS      = 1026;
  localparam int  STALL_CYCLES  = 300;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [ACC_W-1:0] value;
    logic signed [SRC_W-1:0] row;
    logic [COL_W-1:0]        col;
    logic                    last;
  } pool_result_t;

  logic clk;
  logic rst_n;

  spe_in_if  in_if();
  spe_out_if out_if();
  spe_cfg_if cfg_if();

  segment_pooling_engine DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // model state
  longint           col_sum [COLUMNS];
  int               col_best_row [COLUMNS];
  int               row_idx;
  int               seg_rows;
  pool_mode_t       mode_q;
  logic [NCOL_W-1:0] cols_cfg;

  pool_result_t pending_pools[$];

  int     send_gap_pct;
  int     recv_stall_pct;
  int     recv_hold_left;
  int     mismatch_count;
  longint cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      recv_hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pool_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pools.size() == 0) begin
        $error("unexpected result beat: column %0d value %0d",
               out_if.out_column, out_if.pooled_value);
        mismatch_count++;
      end else begin
        exp_r = pending_pools.pop_front();
        if (out_if.pooled_value !== exp_r.value) begin
          $error("pooled_value: expected %0d, got %0d", exp_r.value, out_if.pooled_value);
          mismatch_count++;
        end
        if (out_if.source_row !== exp_r.row) begin
          $error("source_row: expected %0d, got %0d", exp_r.row, out_if.source_row);
          mismatch_count++;
        end
        if (out_if.out_column !== exp_r.col) begin
          $error("out_column: expected %0d, got %0d", exp_r.col, out_if.out_column);
          mismatch_count++;
        end
        if (out_if.last_of_segment !== exp_r.last) begin
          $error("last_of_segment: expected %0d, got %0d", exp_r.last,
                 out_if.last_of_segment);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void clear_columns();
    for (int i = 0; i < COLUMNS; i++) begin
      col_sum[i]      = 0;
      col_best_row[i] = -1;
    end
  endfunction

  function automatic int active_cols();
    if (cols_cfg == 0) return 1;
    if (cols_cfg > COLUMNS) return COLUMNS;
    return int'(cols_cfg);
  endfunction

  // fold one accepted element into the column state, queue its pooled result at a segment end or empty marker
  function automatic void fold_element(action_t act, logic signed [SAMPLE_W-1:0] sample,
                                       logic [COL_W-1:0] col, logic seg_end, logic begins);
    int           ncols;
    logic         last;
    longint       acc;
    longint       pooled;
    int           src;
    pool_result_t r;
    ncols = active_cols();
    last  = (int'(col) == ncols - 1);
    if (int'(col) >= ncols) return;
    if (act == ACT_EMPTY) begin
      r.value = '0;
      r.row   = -1;
      r.col   = col;
      r.last  = last;
      pending_pools.push_back(r);
      return;
    end
    if (begins) begin
      row_idx  = 0;
      seg_rows = 0;
      clear_columns();
    end
    if (mode_q == MODE_MAX) begin
      if (longint'(sample) > col_sum[col]) begin
        col_sum[col]      = longint'(sample);
        col_best_row[col] = row_idx;
      end
    end else begin
      acc = col_sum[col] + longint'(sample);
      if (acc > longint'(ACC_MAX)) acc = longint'(ACC_MAX);
      if (acc < longint'(ACC_MIN)) acc = longint'(ACC_MIN);
      col_sum[col] = acc;
    end
    if (seg_end) begin
      pooled = col_sum[col];
      src    = -1;
      if (mode_q == MODE_MAX) src = col_best_row[col];
      else if (mode_q == MODE_MEAN) pooled = pooled / longint'(seg_rows + 1);
      col_sum[col]      = 0;
      col_best_row[col] = -1;
      r.value = pooled[ACC_W-1:0];
      r.row   = src[SRC_W-1:0];
      r.col   = col;
      r.last  = last;
      pending_pools.push_back(r);
    end
    if (last) begin
      if (row_idx < MAX_ROWS - 1) row_idx++;
      if (seg_end) seg_rows = 0;
      else if (seg_rows < MAX_SEG_ROWS - 1) seg_rows++;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return SAMPLE_W'($urandom_range(0, 511) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(action_t act, logic signed [SAMPLE_W-1:0] sample,
                           logic [COL_W-1:0] col, logic seg_end, logic begins);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.action       <= act;
    in_if.sample       <= sample;
    in_if.column       <= col;
    in_if.segment_end  <= seg_end;
    in_if.input_begins <= begins;
    do @(posedge clk); while (!in_if.ready);
    fold_element(act, sample, col, seg_end, begins);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_POOLING_MODE) mode_q = pool_mode_t'(value[MODE_W-1:0]);
    else cols_cfg = value[NCOL_W-1:0];
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(pool_mode_t mode, logic [NCOL_W-1:0] ncols);
    wait_drained();
    write_reg(REG_POOLING_MODE, {7'($urandom_range(0, 127)), mode});
    write_reg(REG_COLUMNS_IN_USE, ncols);
  endtask

  task automatic test_reset_defaults();
    send_beat(ACT_DATA, 16'sd3, 8'd255, 1'b1, 1'b1);
  endtask

  task automatic test_max_mode();
    set_config(MODE_MAX, 9'd4);
    send_beat(ACT_DATA,  16'sh7FFF, 8'd0, 1'b0, 1'b1);
    send_beat(ACT_DATA,  16'sh8000, 8'd1, 1'b0, 1'b0);
    send_beat(ACT_EMPTY, 16'sh1234, 8'd3, 1'b1, 1'b0);
    send_beat(ACT_DATA,  16'sh0100, 8'd2, 1'b0, 1'b0);
    send_beat(ACT_DATA,  16'sh0000, 8'd3, 1'b0, 1'b0);
    send_beat(ACT_DATA,  16'sh7FFF, 8'd9, 1'b1, 1'b0);
    send_beat(ACT_DATA,  16'sh0001, 8'd0, 1'b1, 1'b0);
    send_beat(ACT_DATA,  16'shFFFF, 8'd1, 1'b1, 1'b0);
    send_beat(ACT_DATA,  16'sh0200, 8'd2, 1'b1, 1'b0);
    send_beat(ACT_DATA,  16'sh0005, 8'd3, 1'b1, 1'b0);
  endtask

  task automatic test_sum_and_mean();
    set_config(MODE_MEAN, 9'd2);
    send_beat(ACT_DATA, -16'sd3,   8'd0, 1'b0, 1'b1);
    send_beat(ACT_DATA, 16'sh7FFF, 8'd1, 1'b0, 1'b0);
    send_beat(ACT_DATA, -16'sd2,   8'd0, 1'b0, 1'b0);
    send_beat(ACT_DATA, 16'sd1,    8'd1, 1'b0, 1'b0);
    send_beat(ACT_DATA, 16'sd0,    8'd0, 1'b1, 1'b0);
    send_beat(ACT_DATA, 16'sd0,    8'd1, 1'b1, 1'b0);
    set_config(MODE_SUM3, 9'd2);
    send_beat(ACT_DATA, 16'sh8000, 8'd0, 1'b1, 1'b1);
    send_beat(ACT_DATA, 16'sh4000, 8'd1, 1'b1, 1'b0);
  endtask

  task automatic test_column_limits();
    set_config(MODE_SUM, 9'd0);
    send_beat(ACT_DATA, 16'sh0040, 8'd0, 1'b1, 1'b1);
    send_beat(ACT_DATA, 16'sh0040, 8'd1, 1'b1, 1'b0);
    set_config(MODE_SUM, 9'd300);
    send_beat(ACT_DATA, 16'sh0010, 8'd255, 1'b1, 1'b0);
  endtask

  task automatic test_mode_switch();
    set_config(MODE_SUM, 9'd1);
    send_beat(ACT_DATA, 16'sh0100, 8'd0, 1'b0, 1'b1);
    send_beat(ACT_DATA, 16'sh0100, 8'd0, 1'b0, 1'b0);
    set_config(MODE_MAX, 9'd1);
    send_beat(ACT_DATA, 16'sh0080, 8'd0, 1'b1, 1'b0);
  endtask

  // one column, one long segment: the sum clamps at its ceiling and the
  // segment row count saturates before the mean divides by it
  task automatic test_saturation_and_counters();
    set_config(MODE_SUM, 9'd1);
    send_beat(ACT_DATA, 16'sh7FFF, 8'd0, 1'b0, 1'b1);
    for (int i = 1; i < SAT_ROWS; i++) send_beat(ACT_DATA, 16'sh7FFF, 8'd0, 1'b0, 1'b0);
    set_config(MODE_MEAN, 9'd1);
    send_beat(ACT_DATA, 16'sh7FFF, 8'd0, 1'b1, 1'b0);
    set_config(MODE_MAX, 9'd1);
    send_beat(ACT_DATA, 16'sh0100, 8'd0, 1'b0, 1'b0);
    send_beat(ACT_DATA, 16'sh0080, 8'd0, 1'b1, 1'b0);
  endtask

  task automatic test_random_matrices(int n_items, int gap_pct, int stall_pct);
    int               done;
    int               ncols;
    int               rows;
    logic [NCOL_W-1:0] cfg_cols;
    logic             seg_end;
    logic             fresh;
    action_t          act;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(9))
        0:       cfg_cols = 9'd0;
        1:       cfg_cols = 9'd1;
        2:       cfg_cols = NCOL_W'($urandom_range(257, 511));
        3:       cfg_cols = ($urandom_range(3) == 0) ? 9'd256 : 9'd2;
        default: cfg_cols = NCOL_W'($urandom_range(2, 8));
      endcase
      set_config(pool_mode_t'($urandom_range(3)), cfg_cols);
      ncols = active_cols();
      rows  = (ncols >= 64) ? 1 : $urandom_range(1, 10);
      fresh = ($urandom_range(3) != 0);
      for (int r = 0; r < rows; r++) begin
        seg_end = ($urandom_range(2) == 0) || (ncols >= 64);
        for (int c = 0; c < ncols; c++) begin
          // wide rows: only the first and last few columns
          if (ncols >= 64 && c > 2 && c < ncols - 3) continue;
          if ($urandom_range(19) == 0)
            send_beat(action_t'($urandom_range(1)), pick_sample(),
                      COL_W'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom_range(7) == 0);
          act = ($urandom_range(15) == 0) ? ACT_EMPTY : ACT_DATA;
          send_beat(act, pick_sample(), COL_W'(c), seg_end, fresh && r == 0 && c == 0);
          done++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_config(MODE_SUM, 9'd2);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    recv_hold_left = STALL_CYCLES;
    for (int i = 0; i < 24; i++)
      send_beat(ACT_DATA, pick_sample(), COL_W'(i % 2), 1'b1, i == 0);
    wait_drained();
    for (int i = 0; i < 8; i++)
      send_beat(ACT_DATA, pick_sample(), COL_W'(i % 2), 1'b1, 1'b0);
  endtask

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.action        = 1'b0;
    in_if.sample        = '0;
    in_if.column        = '0;
    in_if.segment_end   = 1'b0;
    in_if.input_begins  = 1'b0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.idx          = '0;
    cfg_if.data         = '0;
    send_gap_pct        = 6;
    recv_stall_pct      = 49;
    recv_hold_left      = 0;
    mismatch_count      = 0;
    cycle_count         = 0;
    clear_columns();
    row_idx  = 0;
    seg_rows = 0;
    mode_q   = MODE_MAX;
    cols_cfg = NCOL_RESET;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_max_mode();
    test_sum_and_mean();
    test_column_limits();
    test_mode_switch();
    test_random_matrices(30, 6, 49);
    test_random_matrices(30, 49, 6);
    test_random_matrices(30, 0, 0);
    test_saturation_and_counters();
    test_backpressure();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* segment_pooling_engine.f */
rtl/spe_pkg.sv
rtl/spe_ifs.sv
rtl/spe_front.sv
rtl/spe_queue.sv
rtl/spe_back.sv
rtl/segment_pooling_engine.sv
dv/segment_pooling_engine_tb.sv
